[hw/rtl/bpc_pkg.sv]
package bpc_pkg;

  localparam int POS_W       = 16;
  localparam int SAMPLE_W    = 16;
  localparam int BINS_W      = 7;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IDX_OUT_W   = 6;
  localparam int CNT_OUT_W   = 13;
  localparam int CORR_W      = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_PAD_W   = OUT_DATA_W - IDX_OUT_W - CNT_OUT_W - CORR_W;

  localparam int FRAC_SHIFT  = 32;
  localparam int DQ_W        = FRAC_SHIFT + 1;
  localparam int ROOT_W      = 17;

  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_X_LOW  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_X_HIGH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BINS   = 2'd2;

  localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [IDX_OUT_W-1:0]     bin_index;
    logic [CNT_OUT_W-1:0]     pair_count;
    logic signed [CORR_W-1:0] correlation;
  } result_t;

endpackage

[hw/rtl/bpc_mul.sv]
module bpc_mul #(
  parameter int W = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CNT_W = $clog2(W + 1);

  logic [2*W-1:0]   acc_r;
  logic [2*W-1:0]   acc_nxt;
  logic [W-1:0]     a_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       sum;

  always_comb begin
    sum     = {1'b0, acc_r[2*W-1:W]} + (acc_r[0] ? {1'b0, a_r} : {(W + 1){1'b0}});
    acc_nxt = {sum, acc_r[W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= {{W{1'b0}}, b};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[hw/rtl/bpc_div.sv]
module bpc_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);

  localparam int XW    = (NW > DW + QW) ? NW : DW + QW;
  localparam int CNT_W = $clog2(QW + 1);

  logic [XW-1:0]    rem_r;
  logic [XW-1:0]    dsh_r;
  logic [QW-1:0]    q_r;
  logic [QW:0]      q_ext;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  always_comb begin
    ge    = (rem_r >= dsh_r);
    q_ext = {q_r, ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= XW'(num);
      dsh_r <= XW'(den) << (QW - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= q_ext[QW-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[hw/rtl/bpc_corr.sv]
module bpc_corr #(
  parameter int CW  = 13,
  parameter int SUW = 29,
  parameter int SQW = 43
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [CW-1:0]                       n,
  input  logic signed [SUW-1:0]               su,
  input  logic signed [SUW-1:0]               sv,
  input  logic [SQW-1:0]                      suu,
  input  logic [SQW-1:0]                      svv,
  input  logic signed [SQW:0]                 suv,
  output logic                                done,
  output logic signed [bpc_pkg::CORR_W-1:0]   corr
);

  localparam int MW = CW + SQW + 1;
  localparam int PW = 2 * MW;
  localparam int RW = bpc_pkg::ROOT_W;

  typedef enum logic [3:0] {
    C_IDLE, C_NUU, C_UU, C_NVV, C_VV, C_NUV, C_UV, C_AB, C_CC, C_DIV, C_SQRT, C_OUT
  } cstate_t;

  cstate_t                       state_r;
  logic [CW-1:0]                 n_r;
  logic [SUW-1:0]                su_m_r;
  logic [SUW-1:0]                sv_m_r;
  logic [SQW-1:0]                suu_r;
  logic [SQW-1:0]                svv_r;
  logic [SQW:0]                  suv_m_r;
  logic                          neg_uv_r;
  logic                          neg_c2_r;
  logic [MW-1:0]                 t1_r;
  logic [MW-1:0]                 a_r;
  logic [MW-1:0]                 b_r;
  logic [MW-1:0]                 cmag_r;
  logic                          cneg_r;
  logic [PW-1:0]                 p_r;
  logic [PW-1:0]                 csq_r;
  logic [bpc_pkg::DQ_W-1:0]      d_r;
  logic [RW-1:0]                 root_r;
  logic [RW-1:0]                 bit_r;
  logic                          mul_go_r;
  logic                          div_go_r;
  logic                          done_r;
  logic signed [bpc_pkg::CORR_W-1:0] corr_r;

  logic [MW-1:0]                 ma;
  logic [MW-1:0]                 mb;
  logic                          mul_done;
  logic [PW-1:0]                 mul_prod;
  logic                          div_done;
  logic [bpc_pkg::DQ_W-1:0]      div_quot;
  logic [MW:0]                   t1s;
  logic [MW:0]                   t2s;
  logic [MW:0]                   cs;
  logic [MW:0]                   cabs;
  logic [RW-1:0]                 cand;
  logic [2*RW-1:0]               sq;
  logic [RW:0]                   kx;
  logic [RW:0]                   nk;

  always_comb begin
    case (state_r)
      C_NUU: begin ma = MW'(n_r);    mb = MW'(suu_r);   end
      C_UU:  begin ma = MW'(su_m_r); mb = MW'(su_m_r);  end
      C_NVV: begin ma = MW'(n_r);    mb = MW'(svv_r);   end
      C_VV:  begin ma = MW'(sv_m_r); mb = MW'(sv_m_r);  end
      C_NUV: begin ma = MW'(n_r);    mb = MW'(suv_m_r); end
      C_UV:  begin ma = MW'(su_m_r); mb = MW'(sv_m_r);  end
      C_AB:  begin ma = a_r;         mb = b_r;          end
      C_CC:  begin ma = cmag_r;      mb = cmag_r;       end
      default: begin ma = '0;        mb = '0;           end
    endcase
  end

  always_comb begin
    t1s  = neg_uv_r ? (~{1'b0, t1_r}) + 1'b1 : {1'b0, t1_r};
    t2s  = neg_c2_r ? (~{1'b0, mul_prod[MW-1:0]}) + 1'b1 : {1'b0, mul_prod[MW-1:0]};
    cs   = t1s - t2s;
    cabs = cs[MW] ? (~cs) + 1'b1 : cs;
    cand = root_r | bit_r;
    sq   = cand * cand;
    kx   = ({1'b0, root_r} + 1'b1) >> 1;
    nk   = (~kx) + 1'b1;
  end

  bpc_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bpc_div #(.NW(PW + bpc_pkg::FRAC_SHIFT), .DW(PW), .QW(bpc_pkg::DQ_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   ({csq_r, {bpc_pkg::FRAC_SHIFT{1'b0}}}),
    .den   (p_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      done_r   <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            n_r      <= n;
            su_m_r   <= su[SUW-1] ? (~su) + 1'b1 : su;
            sv_m_r   <= sv[SUW-1] ? (~sv) + 1'b1 : sv;
            suu_r    <= suu;
            svv_r    <= svv;
            suv_m_r  <= suv[SQW] ? (~suv) + 1'b1 : suv;
            neg_uv_r <= suv[SQW];
            neg_c2_r <= su[SUW-1] ^ sv[SUW-1];
            mul_go_r <= 1'b1;
            state_r  <= C_NUU;
          end
        end
        C_NUU: begin
          if (mul_done) begin
            t1_r <= mul_prod[MW-1:0]; mul_go_r <= 1'b1; state_r <= C_UU;
          end
        end
        C_UU: begin
          if (mul_done) begin
            a_r <= t1_r - mul_prod[MW-1:0]; mul_go_r <= 1'b1; state_r <= C_NVV;
          end
        end
        C_NVV: begin
          if (mul_done) begin
            t1_r <= mul_prod[MW-1:0]; mul_go_r <= 1'b1; state_r <= C_VV;
          end
        end
        C_VV: begin
          if (mul_done) begin
            b_r <= t1_r - mul_prod[MW-1:0]; mul_go_r <= 1'b1; state_r <= C_NUV;
          end
        end
        C_NUV: begin
          if (mul_done) begin
            t1_r <= mul_prod[MW-1:0]; mul_go_r <= 1'b1; state_r <= C_UV;
          end
        end
        C_UV: begin
          if (mul_done) begin
            cneg_r   <= cs[MW];
            cmag_r   <= cabs[MW-1:0];
            mul_go_r <= 1'b1;
            state_r  <= C_AB;
          end
        end
        C_AB: begin
          if (mul_done) begin
            if (mul_prod == '0) begin
              corr_r  <= '0;
              done_r  <= 1'b1;
              state_r <= C_IDLE;
            end else begin
              p_r      <= mul_prod;
              mul_go_r <= 1'b1;
              state_r  <= C_CC;
            end
          end
        end
        C_CC: begin
          if (mul_done) begin
            csq_r    <= mul_prod;
            div_go_r <= 1'b1;
            state_r  <= C_DIV;
          end
        end
        C_DIV: begin
          if (div_done) begin
            d_r     <= div_quot;
            root_r  <= '0;
            bit_r   <= RW'(1) << (RW - 1);
            state_r <= C_SQRT;
          end
        end
        C_SQRT: begin
          if (sq <= (2 * RW)'(d_r)) begin
            root_r <= cand;
          end
          bit_r <= bit_r >> 1;
          if (bit_r[0]) begin
            state_r <= C_OUT;
          end
        end
        C_OUT: begin
          if (cneg_r) begin
            corr_r <= nk[bpc_pkg::CORR_W-1:0];
          end else if (kx > (RW + 1)'(bpc_pkg::CORR_MAX)) begin
            corr_r <= bpc_pkg::CORR_MAX;
          end else begin
            corr_r <= kx[bpc_pkg::CORR_W-1:0];
          end
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign corr = corr_r;

endmodule

[hw/rtl/binned_pair_correlator.sv]
// Channel | Ports              | Payload (lowest bit first)
// cfg     | cfg_wr_en/addr/wdata | x_low, x_high, bins_in_use by index
// in      | in_t*              | tuser: func; tdata: x_position, sample_u, sample_v
// out     | out_t*             | tuser: status; tdata: bin_index, pair_count, correlation
// One item at a time. Add: the time from one accept to the next is set by the bin-mapping
// divider and the read-modify-write of the bin memories. Query: the add path plus the
// correlator, set by its shift-add multiplier of MW = 2*clog2(PAIRS_PER_BIN+1) + 31 bits,
// the 33-step divider and the 17-step square root. Clear: a pass over all BINS counts, one count per cycle.
// After reset a clearing pass over all BINS bins holds in_tready low.
// A waiting result in the output register does not block acceptance of the next item.
module binned_pair_correlator #(
  parameter int BINS          = 64,
  parameter int PAIRS_PER_BIN = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bpc_pkg::IN_DATA_W-1:0]     in_tdata,   // x_position, sample_u, sample_v
  input  logic [bpc_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bpc_pkg::OUT_DATA_W-1:0]    out_tdata,  // bin_index, pair_count, correlation
  output logic [bpc_pkg::STATUS_W-1:0]      out_tuser   // status
);

  localparam int PW_  = bpc_pkg::POS_W;
  localparam int SW_  = bpc_pkg::SAMPLE_W;
  localparam int IW   = $clog2(BINS);
  localparam int CW   = $clog2(PAIRS_PER_BIN + 1);
  localparam int SUW  = SW_ + CW;
  localparam int SQW  = 2 * SW_ - 2 + CW;
  localparam int UVW  = SQW + 1;
  localparam int SUMW = 2 * SUW + 2 * SQW + UVW;
  localparam int NUMW = PW_ + IW + 2;
  localparam int DENW = PW_ + 1;
  localparam logic [IW-1:0] LAST_BIN = IW'(BINS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(PAIRS_PER_BIN);
  localparam logic [CW-1:0] MIN_CNT  = CW'(2);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MAP, S_DIV, S_RD, S_MOD, S_CORR, S_RES
  } state_t;

  state_t                       state_r;
  logic [IW-1:0]                clr_ptr_r;
  logic                         clr_item_r;
  logic [PW_-1:0]               x_low_r;
  logic [PW_-1:0]               x_high_r;
  logic [bpc_pkg::BINS_W-1:0]   bins_r;
  logic [bpc_pkg::FUNC_W-1:0]   func_r;
  logic signed [SW_-1:0]        u_r;
  logic signed [SW_-1:0]        v_r;
  logic [PW_-1:0]               off_r;
  logic [PW_-1:0]               span_r;
  logic [IW-1:0]                m_r;
  logic [IW-1:0]                idx_r;
  logic signed [2*SW_-1:0]      uu_r;
  logic signed [2*SW_-1:0]      vv_r;
  logic signed [2*SW_-1:0]      uv_r;
  logic [CW-1:0]                cnt_q_r;
  logic [SUMW-1:0]              sum_q_r;
  bpc_pkg::result_t             res_r;
  bpc_pkg::result_t             out_r;
  logic                         out_tvalid_r;

  logic [CW-1:0]                cnt_mem [BINS];
  logic [SUMW-1:0]              sum_mem [BINS];

  logic [PW_-1:0]               x_in;
  logic                         x_bad;
  logic [IW-1:0]                m_comb;
  logic [PW_+IW-1:0]            xm;
  logic [NUMW-1:0]              num;
  logic                         div_go;
  logic                         div_done;
  logic [IW-1:0]                div_quot;
  logic                         corr_go;
  logic                         corr_done;
  logic signed [bpc_pkg::CORR_W-1:0] corr_val;
  logic                         add_wr;
  logic [CW-1:0]                cnt_inc;
  logic signed [SUW-1:0]        old_su;
  logic signed [SUW-1:0]        old_sv;
  logic [SQW-1:0]               old_suu;
  logic [SQW-1:0]               old_svv;
  logic signed [UVW-1:0]        old_suv;
  logic signed [SUW-1:0]        new_su;
  logic signed [SUW-1:0]        new_sv;
  logic [SQW-1:0]               new_suu;
  logic [SQW-1:0]               new_svv;
  logic signed [UVW-1:0]        new_suv;
  logic                         base_zero;

  assign x_in  = in_tdata[PW_-1:0];
  assign x_bad = (x_in < x_low_r) || (x_in > x_high_r);

  always_comb begin
    if (bins_r == '0) begin
      m_comb = '0;
    end else if (32'(bins_r) > 32'(BINS)) begin
      m_comb = LAST_BIN;
    end else begin
      m_comb = IW'(bins_r - 1'b1);
    end
  end

  always_comb begin
    xm      = off_r * m_r;
    num     = NUMW'({xm, 1'b0}) + NUMW'(span_r);
    div_go  = (state_r == S_MAP) && (span_r != '0);
    corr_go = (state_r == S_MOD) && (func_r == bpc_pkg::FUNC_QUERY) && (cnt_q_r >= MIN_CNT);
    add_wr  = (state_r == S_MOD) && (func_r == bpc_pkg::FUNC_ADD) && (cnt_q_r < FULL_CNT);
    cnt_inc = cnt_q_r + 1'b1;
  end

  always_comb begin
    {old_su, old_sv, old_suu, old_svv, old_suv} = sum_q_r;
    base_zero = (cnt_q_r == '0);
    new_su  = (base_zero ? SUW'(0) : old_su) + SUW'(u_r);
    new_sv  = (base_zero ? SUW'(0) : old_sv) + SUW'(v_r);
    new_suu = (base_zero ? SQW'(0) : old_suu) + SQW'(uu_r);
    new_svv = (base_zero ? SQW'(0) : old_svv) + SQW'(vv_r);
    new_suv = (base_zero ? UVW'(0) : old_suv) + UVW'(uv_r);
  end

  bpc_div #(.NW(NUMW), .DW(DENW), .QW(IW)) u_map_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (num),
    .den   ({span_r, 1'b0}),
    .done  (div_done),
    .quot  (div_quot)
  );

  bpc_corr #(.CW(CW), .SUW(SUW), .SQW(SQW)) u_corr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (corr_go),
    .n     (cnt_q_r),
    .su    (old_su),
    .sv    (old_sv),
    .suu   (old_suu),
    .svv   (old_svv),
    .suv   (old_suv),
    .done  (corr_done),
    .corr  (corr_val)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      cnt_mem[clr_ptr_r] <= '0;
    end else if (add_wr) begin
      cnt_mem[idx_r] <= cnt_inc;
    end
    if (add_wr) begin
      sum_mem[idx_r] <= {new_su, new_sv, new_suu, new_svv, new_suv};
    end
    if (state_r == S_RD) begin
      cnt_q_r <= cnt_mem[idx_r];
      sum_q_r <= sum_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r  <= '0;
      x_high_r <= '1;
      bins_r   <= bpc_pkg::BINS_W'(64);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bpc_pkg::REG_X_LOW:  x_low_r  <= cfg_wdata[PW_-1:0];
        bpc_pkg::REG_X_HIGH: x_high_r <= cfg_wdata[PW_-1:0];
        bpc_pkg::REG_BINS:   bins_r   <= cfg_wdata[bpc_pkg::BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_ptr_r    <= '0;
      clr_item_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_RES) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          if (clr_ptr_r == LAST_BIN) begin
            clr_ptr_r <= '0;
            if (clr_item_r) begin
              res_r   <= '0;
              state_r <= S_RES;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            clr_ptr_r <= clr_ptr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            func_r <= in_tuser;
            u_r    <= in_tdata[PW_+SW_-1:PW_];
            v_r    <= in_tdata[PW_+2*SW_-1:PW_+SW_];
            off_r  <= x_in - x_low_r;
            span_r <= x_high_r - x_low_r;
            m_r    <= m_comb;
            res_r.status      <= ((in_tuser inside {bpc_pkg::FUNC_ADD, bpc_pkg::FUNC_QUERY})
                                  && x_bad) ? bpc_pkg::ST_RANGE : bpc_pkg::ST_OK;
            res_r.bin_index   <= '0;
            res_r.pair_count  <= '0;
            res_r.correlation <= '0;
            case (in_tuser)
              bpc_pkg::FUNC_CLEAR: begin
                clr_ptr_r  <= '0;
                clr_item_r <= 1'b1;
                state_r    <= S_CLR;
              end
              bpc_pkg::FUNC_ADD, bpc_pkg::FUNC_QUERY: begin
                state_r <= x_bad ? S_RES : S_MAP;
              end
              default: state_r <= S_RES;
            endcase
          end
        end
        S_MAP: begin
          uu_r <= u_r * u_r;
          vv_r <= v_r * v_r;
          uv_r <= u_r * v_r;
          if (span_r == '0) begin
            idx_r   <= '0;
            state_r <= S_RD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx_r   <= div_quot;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          res_r.bin_index <= bpc_pkg::IDX_OUT_W'(idx_r);
          if (add_wr) begin
            res_r.pair_count <= bpc_pkg::CNT_OUT_W'(cnt_inc);
            res_r.status <= (cnt_inc >= FULL_CNT) ? bpc_pkg::ST_FULL : bpc_pkg::ST_OK;
          end else begin
            res_r.pair_count <= bpc_pkg::CNT_OUT_W'(cnt_q_r);
            if (func_r == bpc_pkg::FUNC_ADD) begin
              res_r.status <= bpc_pkg::ST_DROP;
            end
          end
          state_r <= corr_go ? S_CORR : S_RES;
        end
        S_CORR: begin
          if (corr_done) begin
            res_r.correlation <= corr_val;
            state_r           <= S_RES;
          end
        end
        S_RES: begin
          if (!out_tvalid_r || out_tready) begin
            out_r        <= res_r;
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {{bpc_pkg::OUT_PAD_W{1'b0}}, out_r.correlation, out_r.pair_count,
                       out_r.bin_index};

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while one is at work");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (cnt_q_r <= FULL_CNT))
    else $error("bin count above capacity");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == bpc_pkg::ST_RANGE) |->
    (out_r.bin_index == '0 && out_r.pair_count == '0 && out_r.correlation == '0))
    else $error("out-of-range result carries data");

  a_corr_wait: assert property (@(posedge clk) disable iff (!rst_n)
    corr_done |-> (state_r == S_CORR))
    else $error("correlation done outside its wait state");
`endif

endmodule
